[hdl/peak_cluster_detector_defines.svh]
// Assertion macros shared by the peak cluster detector modules.
// Expects clk and rst in the scope where a macro is used.
`ifndef PEAK_CLUSTER_DETECTOR_DEFINES_SVH
`define PEAK_CLUSTER_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pcd_pkg.sv]
// Package for the peak cluster detector: widths, register codes, entry
// and result types. No dependencies.
package pcd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int POS_W      = 32;
  localparam int CH_FIELD_W = 3;
  localparam int GAP_W      = 8;
  localparam int CFG_IDX_W  = 1;

  localparam int CHANNELS_DEFAULT = 8;

  localparam logic [SAMPLE_W-1:0] CEILING_RESET = 24'h800000;
  localparam logic [GAP_W-1:0]    GAP_RESET     = 8'd4;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CEILING     = 1'b0,
    REG_CLUSTER_GAP = 1'b1
  } cfg_reg_t;

  // Per-channel cluster record held in the state memory.
  typedef struct packed {
    logic [POS_W-1:0]    best_pos;
    logic [SAMPLE_W-1:0] max_mag;
    logic                best_neg;
    logic [POS_W-1:0]    last_pos;
  } entry_t;

  typedef struct packed {
    logic [POS_W-1:0]      pos;
    logic [CH_FIELD_W-1:0] ch;
    logic                  neg;
    logic [SAMPLE_W-1:0]   mag;
    logic                  last;
  } res_t;

  // Results produced by one update, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

[hdl/peak_cluster_detector.sv]
// Peak cluster detector top level: stream ports, configuration port.
// Depends on pcd_pkg, pcd_update and pcd_out_fifo.
//
// Usage:
//   Input transactions on s_axis_*: one audio sample with its position and
//   channel; s_axis_tlast closes the channel's open cluster after the sample.
//   Each closed cluster yields one result transaction on m_axis_* holding
//   the first largest sample of the cluster; m_axis_tlast marks the last
//   result caused by one input (an input causes zero, one or two results).
//   Configuration (ceiling, cluster gap) is written through cfg_we /
//   cfg_index / cfg_data while the block is idle.
//   Throughput: one input per cycle while s_axis_tready is high. Per-channel
//   state sits in a memory with a registered read; a write to the entry read
//   in the same cycle is forwarded. A result passes the update stage register
//   and the result queue before it is offered on m_axis_*.
//   Results go through an 8-entry queue; input is held off (s_axis_tready
//   low) when the queue cannot take two more results per item in flight,
//   so a stalled receiver stops input after a few transactions.
//   Reset (rst, synchronous) closes all clusters, empties the queue and
//   restores the register defaults.
module peak_cluster_detector
  import pcd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [55:0]          s_axis_tdata,   // sample[23:0], position[55:24]
  input  logic [2:0]           s_axis_tuser,   // channel[2:0]
  input  logic                 s_axis_tlast,   // end_of_range
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // peak_position[31:0],
                                               // peak_negative[32],
                                               // peak_magnitude[56:33], zero
  output logic [2:0]           m_axis_tuser,   // peak_channel[2:0]
  output logic                 m_axis_tlast    // last_of_run
);

  logic [FIFO_AW:0] level;
  push_t            push;
  res_t             out_res;

  pcd_update #(
    .CHANNELS(CHANNELS)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata[23:0]),
    .in_pos    (s_axis_tdata[55:24]),
    .in_ch     (s_axis_tuser),
    .in_eor    (s_axis_tlast),
    .level     (level),
    .push      (push)
  );

  pcd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .level     (level),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.mag, out_res.neg, out_res.pos};
  assign m_axis_tuser = out_res.ch;
  assign m_axis_tlast = out_res.last;

endmodule

[hdl/pcd_update.sv]
// Cluster tracker: per-channel state memory, read stage and update stage.
// Depends on pcd_pkg and peak_cluster_detector_defines.svh.
`include "peak_cluster_detector_defines.svh"

module pcd_update
  import pcd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SAMPLE_W-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic [POS_W-1:0]      in_pos,
  input  logic [CH_FIELD_W-1:0] in_ch,
  input  logic                  in_eor,
  input  logic [FIFO_AW:0]      level,
  output push_t                 push
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);
  localparam logic [FIFO_AW+1:0] READY_LIMIT = (FIFO_AW+2)'(FIFO_DEPTH - 2);

  logic [SAMPLE_W-1:0] ceiling;
  logic [GAP_W-1:0]    cluster_gap;

  entry_t              mem [CHANNELS];
  logic [CHANNELS-1:0] open_flags;

  entry_t              rd_entry;
  entry_t              fwd_entry;
  logic                s1_fwd;
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [POS_W-1:0]    s1_pos;
  logic [CH_FIELD_W-1:0] s1_ch;
  logic                s1_eor;

  logic [CH_W-1:0]     in_idx;
  logic [CH_W-1:0]     s1_idx;
  logic                accept;
  logic                s1_ok;
  entry_t              ent;
  entry_t              upd;
  logic                is_open;
  logic                neg;
  logic [SAMPLE_W-1:0] mag;
  logic                above;
  logic [POS_W-1:0]    gap;
  logic                close_gap;
  logic                take;
  logic                open_after;
  logic                flush;
  logic                wr_en;
  res_t                r_gap;
  res_t                r_eor;

  assign in_idx   = CH_W'(in_ch);
  assign s1_idx   = CH_W'(s1_ch);
  assign in_ready = ({1'b0, level} + {{FIFO_AW{1'b0}}, s1_valid, 1'b0}) <= READY_LIMIT;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling     <= CEILING_RESET;
      cluster_gap <= GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CEILING:     ceiling     <= cfg_data;
        REG_CLUSTER_GAP: cluster_gap <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // State memory: one read and one write port, write data forwarded to a
  // read of the same entry in the same cycle.
  always_ff @(posedge clk) begin
    rd_entry  <= mem[in_idx];
    if (wr_en) begin
      mem[s1_idx] <= upd;
    end
    s1_fwd    <= wr_en && (s1_idx == in_idx);
    fwd_entry <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= in_sample;
      s1_pos    <= in_pos;
      s1_ch     <= in_ch;
      s1_eor    <= in_eor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_flags <= '0;
    end else if (s1_ok) begin
      open_flags[s1_idx] <= open_after && !flush;
    end
  end

  always_comb begin
    s1_ok      = s1_valid && ({4'd0, s1_ch} < CH_LIMIT);
    ent        = s1_fwd ? fwd_entry : rd_entry;
    is_open    = open_flags[s1_idx];
    neg        = s1_sample[SAMPLE_W-1];
    mag        = neg ? (~s1_sample + 24'd1) : s1_sample;
    above      = s1_ok && (mag > ceiling);
    gap        = s1_pos - ent.last_pos;
    close_gap  = above && is_open && (gap > {24'd0, cluster_gap});
    take       = above && (!is_open || close_gap || (mag > ent.max_mag));
    open_after = is_open || above;
    flush      = s1_ok && s1_eor && open_after;
    wr_en      = above;

    upd          = ent;
    if (take) begin
      upd.best_pos = s1_pos;
      upd.max_mag  = mag;
      upd.best_neg = neg;
    end
    if (above) begin
      upd.last_pos = s1_pos;
    end

    r_gap = '{pos: ent.best_pos, ch: s1_ch, neg: ent.best_neg,
              mag: ent.max_mag, last: !flush};
    r_eor = '{pos: upd.best_pos, ch: s1_ch, neg: upd.best_neg,
              mag: upd.max_mag, last: 1'b1};

    push.count  = {1'b0, close_gap} + {1'b0, flush};
    push.first  = close_gap ? r_gap : r_eor;
    push.second = r_eor;
  end

  `PCD_ASSERT_NXT(a_flush_closes, flush, !open_flags[$past(s1_idx)], "flush left cluster open")
  `PCD_ASSERT_NXT(a_above_opens, above && !flush, open_flags[$past(s1_idx)], "cluster not opened")
  `PCD_ASSERT_IMP(a_two_results, push.count == 2'd2, above && s1_eor, "two results without gap and flush")
  `PCD_ASSERT_IMP(a_no_spurious, !s1_ok, push.count == 2'd0, "result from idle or ignored item")

endmodule

[hdl/pcd_out_fifo.sv]
// Result queue: takes up to two results a cycle, delivers one a cycle while out_ready is high.
// Depends on pcd_pkg and peak_cluster_detector_defines.svh.
`include "peak_cluster_detector_defines.svh"

module pcd_out_fifo
  import pcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  output logic [FIFO_AW:0] level,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             out_res
);

  localparam logic [FIFO_AW:0] DEPTH_LEVEL = (FIFO_AW+1)'(FIFO_DEPTH);

  res_t               q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr_inc;
  logic               pop;

  assign out_valid  = level != '0;
  assign pop        = out_valid && out_ready;
  assign out_res    = q[rd_ptr];
  assign wr_ptr_inc = wr_ptr + FIFO_AW'(1);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      q[wr_ptr_inc] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      level <= level + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
    end
  end

  `PCD_ASSERT_IMP(a_level_bound, 1'b1, level <= DEPTH_LEVEL, "queue overflow")
  `PCD_ASSERT_NXT(a_push_two, push.count == 2'd2 && !pop, level == $past(level) + 2'd2, "double push lost")
  `PCD_ASSERT_NXT(a_pop_only, push.count == 2'd0 && pop, level == $past(level) - 1'b1, "pop miscounted")

endmodule

[bench/tb.sv]
// Testbench for peak_cluster_detector: directed table, then randomized cluster traffic.
// Each result is checked against an in-bench predictor of the per-channel peak tracking, or a typed directed result.
// Depends on pcd_pkg and the peak_cluster_detector RTL.
module tb;
  import pcd_pkg::*;

  localparam int NCH          = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 192;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0]  cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [55:0]          s_axis_tdata;   // sample[23:0], position[55:24]
  logic [2:0]           s_axis_tuser;   // channel[2:0]
  logic                 s_axis_tlast;   // end_of_range
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [63:0]          m_axis_tdata;   // peak_position[31:0], peak_negative[32],
                                        // peak_magnitude[56:33], zero
  logic [2:0]           m_axis_tuser;   // peak_channel[2:0]
  logic                 m_axis_tlast;   // last_of_run

  peak_cluster_detector u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  typedef struct {
    logic                is_cfg;
    cfg_reg_t            reg_sel;
    logic [SAMPLE_W-1:0] reg_val;
    logic [SAMPLE_W-1:0] smp;
    logic [POS_W-1:0]    pos;
    logic [2:0]          ch;
    logic                eor;
    int                  n_typed;   // -1: predicted, else typed count
    res_t                typed;
  } dir_step_t;

  // predictor state
  logic [SAMPLE_W-1:0] ceil_q;
  logic [GAP_W-1:0]    gap_q;
  logic                open_q   [NCH];
  logic [POS_W-1:0]    best_pos [NCH];
  logic [SAMPLE_W-1:0] max_mag  [NCH];
  logic                best_neg [NCH];
  logic [POS_W-1:0]    last_pos [NCH];

  res_t        peaks_due[$];
  res_t        want;
  logic [31:0] chan_pos [NCH];
  logic        no_idle;
  int          n_errors;
  int          n_items;
  int          n_checked;
  int          cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, peaks_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    n_errors++;
    if (n_errors <= 40)
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, exp_v, n_checked);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] exp_v);
    if (got !== exp_v) report_mismatch(what, got, exp_v);
  endtask

  function automatic res_t close_cluster(input logic [2:0] ch);
    res_t r;
    r.pos  = best_pos[ch];
    r.ch   = ch;
    r.neg  = best_neg[ch];
    r.mag  = max_mag[ch];
    r.last = 1'b0;
    open_q[ch]   = 1'b0;
    best_pos[ch] = '0;
    max_mag[ch]  = '0;
    best_neg[ch] = 1'b0;
    return r;
  endfunction

  task automatic predict_peaks(input logic [SAMPLE_W-1:0] smp, input logic [POS_W-1:0] pos,
                               input logic [2:0] ch, input logic eor,
                               input int n_typed, input res_t typed);
    logic                neg;
    logic [24:0]         wide;
    logic [SAMPLE_W-1:0] mag;
    logic [POS_W-1:0]    span;
    res_t                r_a;
    res_t                r_b;
    int                  n;
    neg  = smp[23];
    wide = neg ? (25'h1000000 - {1'b0, smp}) : {1'b0, smp};
    mag  = wide[23:0];
    n    = 0;
    if (mag > ceil_q) begin
      span = pos - last_pos[ch];
      if (open_q[ch] && span > {24'd0, gap_q}) begin
        r_a = close_cluster(ch);
        n++;
      end
      if (!open_q[ch] || mag > max_mag[ch]) begin
        best_pos[ch] = pos;
        max_mag[ch]  = mag;
        best_neg[ch] = neg;
      end
      last_pos[ch] = pos;
      open_q[ch]   = 1'b1;
    end
    if (eor && open_q[ch]) begin
      if (n == 0) r_a = close_cluster(ch);
      else r_b = close_cluster(ch);
      n++;
    end
    if (n == 1) r_a.last = 1'b1;
    if (n == 2) r_b.last = 1'b1;
    if (n_typed < 0) begin
      if (n >= 1) peaks_due = {peaks_due, r_a};
      if (n == 2) peaks_due = {peaks_due, r_b};
    end else if (n_typed == 1) begin
      peaks_due = {peaks_due, typed};
    end
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [POS_W-1:0] pos,
                             input logic [2:0] ch, input logic eor,
                             input int n_typed, input res_t typed);
    while (!no_idle && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {pos, smp};
    s_axis_tuser  = ch;
    s_axis_tlast  = eor;
    do @(posedge clk); while (!s_axis_tready);
    predict_peaks(smp, pos, ch, eor, n_typed, typed);
    n_items++;
    @(negedge clk);
  endtask

  // drains all outstanding results, then writes one register
  task automatic write_reg(input cfg_reg_t sel, input logic [SAMPLE_W-1:0] val);
    s_axis_tvalid = 1'b0;
    while (peaks_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (sel == REG_CEILING) ceil_q = val;
    else gap_q = val[GAP_W-1:0];
  endtask

  function automatic logic [SAMPLE_W-1:0] gen_sample();
    logic [SAMPLE_W-1:0] s;
    int m;
    int d;
    int t;
    case ($urandom_range(0, 9))
      0: s = SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: s = 24'h800000;
          1: s = 24'h7FFFFF;
          2: s = 24'h000000;
          default: s = 24'hFFFFFF;
        endcase
      end
      default: begin
        d = $urandom_range(0, 1) ? 16 : 4096;
        m = int'(ceil_q) - d + int'($urandom_range(0, 2 * d));
        if (m < 0) m = 0;
        if (m > 8388608) m = 8388608;
        t = (m == 8388608 || $urandom_range(0, 1)) ? -m : m;
        s = t[SAMPLE_W-1:0];
      end
    endcase
    return s;
  endfunction

  function automatic dir_step_t item_row(input logic [SAMPLE_W-1:0] smp,
                                         input logic [POS_W-1:0] pos, input logic [2:0] ch,
                                         input logic eor, input int n_typed,
                                         input logic [POS_W-1:0] tpos, input logic tneg,
                                         input logic [SAMPLE_W-1:0] tmag);
    dir_step_t r;
    r.is_cfg     = 1'b0;
    r.reg_sel    = REG_CEILING;
    r.reg_val    = '0;
    r.smp        = smp;
    r.pos        = pos;
    r.ch         = ch;
    r.eor        = eor;
    r.n_typed    = n_typed;
    r.typed.pos  = tpos;
    r.typed.ch   = ch;
    r.typed.neg  = tneg;
    r.typed.mag  = tmag;
    r.typed.last = 1'b1;
    return r;
  endfunction

  function automatic dir_step_t cfg_row(input cfg_reg_t sel, input logic [SAMPLE_W-1:0] val);
    dir_step_t r;
    r         = item_row('0, '0, '0, 1'b0, 0, '0, 1'b0, '0);
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = no_idle || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (peaks_due.size() == 0) begin
        report_mismatch("result with none due, position", m_axis_tdata[31:0], '0);
      end else begin
        want = peaks_due.pop_front();
        check_field("peak_position", m_axis_tdata[31:0], want.pos);
        check_field("peak_channel", {29'd0, m_axis_tuser}, {29'd0, want.ch});
        check_field("peak_negative", {31'd0, m_axis_tdata[32]}, {31'd0, want.neg});
        check_field("peak_magnitude", {8'd0, m_axis_tdata[56:33]}, {8'd0, want.mag});
        check_field("last_of_run", {31'd0, m_axis_tlast}, {31'd0, want.last});
        n_checked++;
      end
    end
  end

  initial begin
    dir_step_t    dir_q[$];
    dir_step_t    st;
    res_t         no_res;
    int           p;
    int           k;
    logic [2:0]   ch;
    logic [23:0]  ceil_v;
    logic [7:0]   gap_v;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_CEILING;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    no_idle       = 1'b0;
    n_errors      = 0;
    n_items       = 0;
    n_checked     = 0;
    no_res        = '0;
    ceil_q        = CEILING_RESET;
    gap_q         = GAP_RESET;
    for (k = 0; k < NCH; k++) begin
      open_q[k]   = 1'b0;
      best_pos[k] = '0;
      max_mag[k]  = '0;
      best_neg[k] = 1'b0;
      last_pos[k] = '0;
    end

    // reset values: nothing can exceed the ceiling, flush of an empty channel
    dir_q = {dir_q, item_row(24'h800000, 32'd0, 3'd0, 1'b1, 0, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'h7FFFFF, 32'd1, 3'd1, 1'b1, 0, '0, 1'b0, '0)};
    dir_q = {dir_q, cfg_row(REG_CEILING, 24'd100)};
    dir_q = {dir_q, cfg_row(REG_CLUSTER_GAP, 24'd0)};
    // full-scale samples flushed at once
    dir_q = {dir_q, item_row(24'h800000, 32'd10, 3'd2, 1'b1, 1, 32'd10, 1'b1, 24'h800000)};
    dir_q = {dir_q, item_row(24'h7FFFFF, 32'hFFFFFFFF, 3'd7, 1'b1, 1, 32'hFFFFFFFF, 1'b0,
                             24'h7FFFFF)};
    // tie keeps the earlier sample, gap close, flush with a sample at the ceiling
    dir_q = {dir_q, item_row(24'd101, 32'd20, 3'd3, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(-24'd200, 32'd20, 3'd3, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd200, 32'd20, 3'd3, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd150, 32'd21, 3'd3, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd100, 32'd21, 3'd3, 1'b1, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd5, 32'd22, 3'd3, 1'b1, 0, '0, 1'b0, '0)};
    dir_q = {dir_q, cfg_row(REG_CLUSTER_GAP, 24'd255)};
    // gap of exactly the limit keeps the cluster, one more closes it: two results
    dir_q = {dir_q, item_row(24'd500, 32'd1000, 3'd4, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(-24'd600, 32'd1255, 3'd4, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd700, 32'd1511, 3'd4, 1'b1, -1, '0, 1'b0, '0)};
    // position stepping backwards
    dir_q = {dir_q, item_row(24'd300, 32'd50, 3'd5, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd400, 32'd40, 3'd5, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd0, 32'd40, 3'd5, 1'b1, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, cfg_row(REG_CEILING, 24'd0)};
    dir_q = {dir_q, item_row(24'd1, 32'd0, 3'd6, 1'b1, 1, 32'd0, 1'b0, 24'd1)};
    dir_q = {dir_q, item_row(24'd0, 32'd5, 3'd6, 1'b1, 0, '0, 1'b0, '0)};
    // interleaved channels
    dir_q = {dir_q, item_row(24'hFFFFFF, 32'd7, 3'd0, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd2, 32'd7, 3'd1, 1'b0, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd0, 32'd8, 3'd0, 1'b1, -1, '0, 1'b0, '0)};
    dir_q = {dir_q, item_row(24'd0, 32'd8, 3'd1, 1'b1, -1, '0, 1'b0, '0)};

    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (dir_q[i]) begin
      st = dir_q[i];
      if (st.is_cfg) write_reg(st.reg_sel, st.reg_val);
      else send_sample(st.smp, st.pos, st.ch, st.eor, st.n_typed, st.typed);
    end

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ceil_v = CEILING_RESET; gap_v = GAP_RESET; end
        1: begin ceil_v = 24'd0;         gap_v = 8'd0;      end
        2: begin ceil_v = 24'h7FFFFF;    gap_v = 8'd255;    end
        default: begin
          ceil_v = 24'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                            : $urandom_range(0, 8388608));
          gap_v  = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(REG_CEILING, ceil_v);
      write_reg(REG_CLUSTER_GAP, {16'd0, gap_v});
      for (k = 0; k < NCH; k++)
        chan_pos[k] = ($urandom_range(0, 3) == 0) ? 32'hFFFFFFF0 : $urandom;
      no_idle = (p == 3);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        ch = 3'($urandom_range(0, NCH - 1));
        case ($urandom_range(0, 49))
          0: chan_pos[ch] = $urandom;
          1: chan_pos[ch] = chan_pos[ch] - $urandom_range(1, 8);
          default: chan_pos[ch] = chan_pos[ch] + $urandom_range(0, gap_q + 2);
        endcase
        send_sample(gen_sample(), chan_pos[ch], ch, ($urandom_range(0, 99) < 8), -1, no_res);
      end
      no_idle = 1'b0;
    end

    s_axis_tvalid = 1'b0;
    while (peaks_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d samples over %0d register settings, checked %0d peak results.",
             n_items, PHASES + 4, n_checked);
    $display("Mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
